[design/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared constants, register codes and pipeline word types of the sprite
// blit sampler.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int STORE_DEPTH   = 4096;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);

  localparam logic [7:0] ALPHA_MIN = 8'd16;

  // Divider geometry: 16-bit dividend, 11-bit divisor, 11 quotient bits.
  localparam int DIV_NW = 16;
  localparam int DIV_DW = 11;
  localparam int DIV_QW = 11;

  // Width used to range-check store addresses against the depth.
  localparam int ADDR_CW = 17;

  // Clock edges from the accept edge to the edge that takes the result.
  localparam int PIPE_LAT = 2 * DIV_QW + 3;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_SCALE_NUM    = 3'd2,
    REG_SCALE_DEN    = 3'd3,
    REG_ANCHOR_X     = 3'd4,
    REG_ANCHOR_Y     = 3'd5,
    REG_OFFSET_X     = 3'd6,
    REG_OFFSET_Y     = 3'd7
  } reg_idx_e;

  // Word carried alongside the scale dividers.
  typedef struct packed {
    logic        draw;
    logic [11:0] idx;
    logic [31:0] rgba;
    logic [8:0]  dx;
    logic [8:0]  dy;
    logic        offx_neg;
    logic        offy_neg;
  } item_a_t;

  // Word carried alongside the sampling dividers.
  typedef struct packed {
    logic        draw;
    logic [11:0] idx;
    logic [31:0] rgba;
    logic        ok;
    logic [9:0]  px;
    logic [9:0]  py;
  } item_b_t;

  function automatic logic [15:0] rgb565(input logic [31:0] texel);
    rgb565 = {texel[31:27], texel[23:18], texel[15:11]};
  endfunction

endpackage

[design/ssb_ram.sv]
// ----------------------------------------------------------------------------
// ssb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/ssb_div.sv]
// ----------------------------------------------------------------------------
// ssb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssb_div import ssb_pkg::*; (
  input  logic              clk_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_NW-1:0] rem_q [DIV_QW];
  logic [DIV_DW-1:0] dsr_q [DIV_QW];
  logic [DIV_QW-1:0] quo_q [DIV_QW];

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    localparam int B = DIV_QW - 1 - s;
    logic [DIV_NW-1:0]        rem_in;
    logic [DIV_DW-1:0]        dsr_in;
    logic [DIV_QW-1:0]        quo_in;
    logic [DIV_NW+DIV_QW-1:0] trial;
    logic                     ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign dsr_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Try the shifted divisor; subtract and set the bit where it fits.
    assign trial = {{(DIV_NW+DIV_QW-DIV_DW){1'b0}}, dsr_in} << B;
    assign ge    = {{DIV_QW{1'b0}}, rem_in} >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? rem_in - trial[DIV_NW-1:0] : rem_in;
      dsr_q[s] <= dsr_in;
      quo_q[s] <= quo_in | (DIV_QW'(ge) << B);
    end
  end

  assign quo_o = quo_q[DIV_QW-1];

endmodule

[design/scaled_sprite_blit_sampler_top.sv]
// ----------------------------------------------------------------------------
// scaled_sprite_blit_sampler_top
// Throughput: one word per cycle, loads and draws alike; busy_o stays low.
// The rate is set by the single frame store port: each word uses it once.
// Reset is asynchronous; configuration registers and valid flags return to
// their reset values, the frame store is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// Nearest-neighbor scaled sprite sampler. Loads and draws run down the same
// pipeline so a load writes the store in the very slot where draws read it,
// which keeps store accesses in accept order with no forwarding.
//   1. Scale dividers: w*num/den, h*num/den and |offset*num|/den.
//   2. Grid and screen checks, source dividends dx*w and dy*h.
//   3. Sampling dividers: dx*w/out_w and dy*h/out_h.
//   4. Store access: write a load, or read the texel of a draw.
//   5. Alpha test, RGB565 packing and the result register.
// ----------------------------------------------------------------------------
module scaled_sprite_blit_sampler_top import ssb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [11:0] texel_index_i,
  input  logic [31:0] texel_rgba_i,
  input  logic [8:0]  out_col_i,
  input  logic [8:0]  out_row_i,
  // result channel
  output logic        result_valid_o,
  output logic [9:0]  dest_x_o,
  output logic [9:0]  dest_y_o,
  output logic [15:0] color_o,
  output logic        write_pixel_o,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0]  fw_q, fh_q;
  logic [3:0]  num_q, den_q;
  logic [10:0] ax_q, ay_q;
  logic [6:0]  ox_q, oy_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;
  assign cfg_idx  = reg_idx_e'(paddr_i[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 7'd16;
      fh_q  <= 7'd16;
      num_q <= 4'd1;
      den_q <= 4'd1;
      ax_q  <= '0;
      ay_q  <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  fw_q  <= pwdata_i[6:0];
        REG_FRAME_HEIGHT: fh_q  <= pwdata_i[6:0];
        REG_SCALE_NUM:    num_q <= pwdata_i[3:0];
        REG_SCALE_DEN:    den_q <= pwdata_i[3:0];
        REG_ANCHOR_X:     ax_q  <= pwdata_i[10:0];
        REG_ANCHOR_Y:     ay_q  <= pwdata_i[10:0];
        REG_OFFSET_X:     ox_q  <= pwdata_i[6:0];
        REG_OFFSET_Y:     oy_q  <= pwdata_i[6:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata_o = {25'd0, fw_q};
      REG_FRAME_HEIGHT: prdata_o = {25'd0, fh_q};
      REG_SCALE_NUM:    prdata_o = {28'd0, num_q};
      REG_SCALE_DEN:    prdata_o = {28'd0, den_q};
      REG_ANCHOR_X:     prdata_o = {21'd0, ax_q};
      REG_ANCHOR_Y:     prdata_o = {21'd0, ay_q};
      REG_OFFSET_X:     prdata_o = {25'd0, ox_q};
      REG_OFFSET_Y:     prdata_o = {25'd0, oy_q};
      default:          prdata_o = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Accept: the pipeline never stalls, so every start is taken.
  // --------------------------------------------------------------------------
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // --------------------------------------------------------------------------
  // Stage 1: scale dividers. The user must keep config stable while items are
  // in flight (the block does not enforce this), so read it live wherever needed.
  // --------------------------------------------------------------------------
  logic [10:0]       pw, ph, pox, poy;
  logic [6:0]        ox_mag, oy_mag;
  logic [DIV_QW-1:0] ow_quo, oh_quo, sox_quo, soy_quo;

  assign pw     = fw_q * num_q;
  assign ph     = fh_q * num_q;
  assign ox_mag = ox_q[6] ? 7'(-ox_q) : ox_q;
  assign oy_mag = oy_q[6] ? 7'(-oy_q) : oy_q;
  assign pox    = ox_mag * num_q;
  assign poy    = oy_mag * num_q;

  ssb_div u_div_ow  (.clk_i, .num_i(DIV_NW'(pw)),  .den_i(DIV_DW'(den_q)), .quo_o(ow_quo));
  ssb_div u_div_oh  (.clk_i, .num_i(DIV_NW'(ph)),  .den_i(DIV_DW'(den_q)), .quo_o(oh_quo));
  ssb_div u_div_sox (.clk_i, .num_i(DIV_NW'(pox)), .den_i(DIV_DW'(den_q)), .quo_o(sox_quo));
  ssb_div u_div_soy (.clk_i, .num_i(DIV_NW'(poy)), .den_i(DIV_DW'(den_q)), .quo_o(soy_quo));

  // Carry the word alongside the dividers.
  item_a_t sa_q [DIV_QW];
  logic    va_q [DIV_QW];
  item_a_t sa_d;

  always_comb begin
    sa_d.draw     = req_type_i;
    sa_d.idx      = texel_index_i;
    sa_d.rgba     = texel_rgba_i;
    sa_d.dx       = out_col_i;
    sa_d.dy       = out_row_i;
    sa_d.offx_neg = ox_q[6];
    sa_d.offy_neg = oy_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_QW; i++) begin
        va_q[i] <= 1'b0;
      end
    end else begin
      va_q[0] <= accept;
      for (int i = 1; i < DIV_QW; i++) begin
        va_q[i] <= va_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q[0] <= sa_d;
    for (int i = 1; i < DIV_QW; i++) begin
      sa_q[i] <= sa_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: position, grid and screen checks; dividends for sampling.
  // --------------------------------------------------------------------------
  item_a_t            ta;
  logic signed [12:0] sox, soy, px, py;
  logic               grid_ok, scr_ok;
  item_b_t            mb_d, mb_q;
  logic               mv_q;
  logic [DIV_NW-1:0]  mbx_q, mby_q;
  logic [DIV_DW-1:0]  mow_q, moh_q;

  assign ta = sa_q[DIV_QW-1];

  always_comb begin
    sox = $signed({2'b00, sox_quo});
    soy = $signed({2'b00, soy_quo});
    if (ta.offx_neg) begin
      sox = -sox;
    end
    if (ta.offy_neg) begin
      soy = -soy;
    end
    px = $signed({{2{ax_q[10]}}, ax_q}) + sox + $signed({4'b0000, ta.dx});
    py = $signed({{2{ay_q[10]}}, ay_q}) + soy + $signed({4'b0000, ta.dy});

    grid_ok = (num_q != '0) && (den_q != '0) && (ow_quo != '0) && (oh_quo != '0)
           && ({2'b00, ta.dx} < ow_quo) && ({2'b00, ta.dy} < oh_quo);
    scr_ok  = (px >= 13'sd0) && (px < $signed(13'(SCREEN_WIDTH)))
           && (py >= 13'sd0) && (py < $signed(13'(SCREEN_HEIGHT)));

    mb_d.draw = ta.draw;
    mb_d.idx  = ta.idx;
    mb_d.rgba = ta.rgba;
    mb_d.ok   = grid_ok & scr_ok;
    mb_d.px   = px[9:0];
    mb_d.py   = py[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= va_q[DIV_QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mb_q  <= mb_d;
    mbx_q <= DIV_NW'(ta.dx) * DIV_NW'(fw_q);
    mby_q <= DIV_NW'(ta.dy) * DIV_NW'(fh_q);
    mow_q <= ow_quo;
    moh_q <= oh_quo;
  end

  // --------------------------------------------------------------------------
  // Stage 3: sampling dividers pick the source column and row.
  // --------------------------------------------------------------------------
  logic [DIV_QW-1:0] sx_quo, sy_quo;

  ssb_div u_div_sx (.clk_i, .num_i(mbx_q), .den_i(mow_q), .quo_o(sx_quo));
  ssb_div u_div_sy (.clk_i, .num_i(mby_q), .den_i(moh_q), .quo_o(sy_quo));

  item_b_t sb_q [DIV_QW];
  logic    vb_q [DIV_QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_QW; i++) begin
        vb_q[i] <= 1'b0;
      end
    end else begin
      vb_q[0] <= mv_q;
      for (int i = 1; i < DIV_QW; i++) begin
        vb_q[i] <= vb_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= mb_q;
    for (int i = 1; i < DIV_QW; i++) begin
      sb_q[i] <= sb_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: frame store access. Source row and column only matter when the
  // grid check passed, and then they sit below the frame size.
  // --------------------------------------------------------------------------
  item_b_t              tb;
  logic                 tv;
  logic [13:0]          row_base;
  logic [ADDR_CW-1:0]   tex_addr, load_addr;
  logic                 tex_ok, load_ok;
  logic                 ram_we;
  logic [STORE_AW-1:0]  ram_addr;
  logic [31:0]          ram_rdata;
  logic                 rv_q, rdraw_q;
  logic                 rok_q;
  logic [9:0]           rpx_q, rpy_q;

  assign tb        = sb_q[DIV_QW-1];
  assign tv        = vb_q[DIV_QW-1];
  assign row_base  = sy_quo[6:0] * fw_q;
  assign tex_addr  = ADDR_CW'(row_base) + ADDR_CW'(sx_quo[6:0]);
  assign load_addr = ADDR_CW'(tb.idx);
  assign tex_ok    = tex_addr < ADDR_CW'(STORE_DEPTH);
  assign load_ok   = load_addr < ADDR_CW'(STORE_DEPTH);

  // Drop loads beyond the store.
  assign ram_we   = tv & ~tb.draw & load_ok;
  assign ram_addr = tb.draw ? tex_addr[STORE_AW-1:0] : load_addr[STORE_AW-1:0];

  ssb_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i,
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(tb.rgba),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= tv;
    end
  end

  always_ff @(posedge clk_i) begin
    rdraw_q <= tb.draw;
    rok_q   <= tb.ok & tex_ok;
    rpx_q   <= tb.px;
    rpy_q   <= tb.py;
  end

  // --------------------------------------------------------------------------
  // Stage 5: alpha test and result register. Zero the fields of a skipped
  // pixel.
  // --------------------------------------------------------------------------
  logic        res_v_q, wr_q;
  logic [9:0]  sx_q, sy_q;
  logic [15:0] col_q;
  logic        hit;

  assign hit = rok_q & (ram_rdata[7:0] >= ALPHA_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= rv_q & rdraw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q  <= hit;
    sx_q  <= hit ? rpx_q : '0;
    sy_q  <= hit ? rpy_q : '0;
    col_q <= hit ? rgb565(ram_rdata) : '0;
  end

  assign result_valid_o = res_v_q;
  assign write_pixel_o  = res_v_q & wr_q;
  assign dest_x_o       = res_v_q ? sx_q : '0;
  assign dest_y_o       = res_v_q ? sy_q : '0;
  assign color_o        = res_v_q ? col_q : '0;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_draw_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i) |-> ##PIPE_LAT result_valid_o)
    else $error("draw word did not produce a result in time");

  a_load_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req_type_i) |-> ##PIPE_LAT !result_valid_o)
    else $error("load word produced a result");

  a_on_screen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_pixel_o |-> ((dest_x_o < 10'(SCREEN_WIDTH))
                    && (dest_y_o < 10'(SCREEN_HEIGHT))))
    else $error("pixel written off screen");

  a_store_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (tv && !tb.draw))
    else $error("store written outside a load slot");

endmodule
